// File: rtl/mrt_pkg.sv
// Shared types, codes and constants of the mesh route table engine.
package mrt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam logic [7:0] OWN_ID_RST = 8'd1;

  // Action codes
  localparam logic [2:0] ACT_HEARD  = 3'd0;
  localparam logic [2:0] ACT_ADV    = 3'd1;
  localparam logic [2:0] ACT_LOOKUP = 3'd2;
  localparam logic [2:0] ACT_AGE    = 3'd3;
  localparam logic [2:0] ACT_PURGE  = 3'd4;
  localparam logic [2:0] ACT_DUMP   = 3'd5;

  // Table write operations
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_UPDATE = 3'd1;
  localparam logic [2:0] WR_AGE    = 3'd2;
  localparam logic [2:0] WR_SHIFT  = 3'd3;
  localparam logic [2:0] WR_PURGE  = 3'd4;
  localparam logic [2:0] WR_INSERT = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] node;
    logic [7:0] hops;
    logic [7:0] adv_source;
    logic [7:0] sender;
  } in_t;

  typedef struct packed {
    logic [7:0] next_hop;
    logic [7:0] entry_node;
    logic [7:0] entry_hops;
    logic [7:0] entry_next_hop;
    logic       entry_valid;
    logic [5:0] beacon_length;
    logic [4:0] entry_count;
    logic       table_full;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       active;
    logic [7:0] node;
    logic [7:0] hops;
    logic [7:0] next_hop;
  } ent_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       idx_init_up;
    logic       idx_init_down;
    logic       rd_en;
    logic       rd_down;
    logic [2:0] wr_op;
    logic       nh_latch;
    logic       full_set;
    logic       purge_fin;
    logic       out_load;
    logic       out_entry;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       adv_skip;
    logic       used_zero;
    logic       table_full;
    logic       idx_more_up;
    logic       idx_nz;
    logic       dv;
    logic       match;
    logic       last_dk;
    logic       dk_zero;
    logic       src_own;
    logic       out_free;
  } sta_t;

endpackage

// File: rtl/mesh_route_table_engine.sv
// Top level of the mesh route table engine: controller, datapath and checks.
//
// Distance-vector route table of DEPTH entries kept newest first in a
// single-port-write, registered-read memory, walked by a controller one entry
// per cycle; a dump instead waits after each read until the output register
// is free. A lookup or an update of a known node takes at most one pass over
// the entries in use, age and purge one pass each, and adding a new node a
// pass to search and a pass to move every entry down a place. The single
// memory read port is stepped one address per cycle. Items are taken one at
// a time; the next item is taken as soon as the last result sits in the
// output register, even while that result is still stalled.
module mesh_route_table_engine import mrt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  cmd_t cmd;
  sta_t sta;

  mrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sta      (sta),
    .cmd      (cmd)
  );

  mrt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sta         (sta),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transfer");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.entry_valid) |->
      (out_data.next_hop == 8'd0 && !out_data.table_full))
    else $error("dump entry carries lookup or full flag");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.entry_valid) |-> out_data.last)
    else $error("non-dump result without last");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> in_stall)
    else $error("input taken while an item is in progress");

endmodule

// File: rtl/mrt_ctrl.sv
// Controller state machine of the mesh route table engine.
module mrt_ctrl import mrt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sta_t sta,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_SCAN      = 4'd2;
  localparam logic [3:0] S_SHIFT     = 4'd3;
  localparam logic [3:0] S_INSERT    = 4'd4;
  localparam logic [3:0] S_AGE       = 4'd5;
  localparam logic [3:0] S_PURGE     = 4'd6;
  localparam logic [3:0] S_DUMP_RD   = 4'd7;
  localparam logic [3:0] S_DUMP_WAIT = 4'd8;
  localparam logic [3:0] S_EMIT      = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.wr_op = WR_NONE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        cmd.idx_init_up = 1'b1;
        case (sta.action)
          ACT_HEARD, ACT_ADV: begin
            if (sta.action == ACT_ADV && sta.adv_skip) state_nxt = S_EMIT;
            else if (sta.used_zero) state_nxt = S_INSERT;
            else state_nxt = S_SCAN;
          end
          ACT_LOOKUP: state_nxt = sta.used_zero ? S_EMIT : S_SCAN;
          ACT_AGE:    state_nxt = sta.used_zero ? S_EMIT : S_AGE;
          ACT_PURGE:  state_nxt = sta.used_zero ? S_EMIT : S_PURGE;
          ACT_DUMP:   state_nxt = sta.used_zero ? S_EMIT : S_DUMP_RD;
          default:    state_nxt = S_EMIT;
        endcase
      end
      S_SCAN: begin
        cmd.rd_en = sta.idx_more_up;
        if (sta.dv && sta.match) begin
          if (sta.action == ACT_LOOKUP) cmd.nh_latch = 1'b1;
          else cmd.wr_op = WR_UPDATE;
          state_nxt = S_EMIT;
        end else if (sta.dv && sta.last_dk) begin
          if (sta.action == ACT_LOOKUP || sta.src_own) begin
            state_nxt = S_EMIT;
          end else if (sta.table_full) begin
            cmd.full_set = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.idx_init_down = 1'b1;
            state_nxt         = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // move entries down one place, last entry first
        cmd.rd_en   = sta.idx_nz;
        cmd.rd_down = 1'b1;
        if (sta.dv) begin
          cmd.wr_op = WR_SHIFT;
          if (sta.dk_zero) state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.wr_op = WR_INSERT;
        state_nxt = S_EMIT;
      end
      S_AGE: begin
        cmd.rd_en = sta.idx_more_up;
        if (sta.dv) begin
          cmd.wr_op = WR_AGE;
          if (sta.last_dk) state_nxt = S_EMIT;
        end
      end
      S_PURGE: begin
        cmd.rd_en = sta.idx_more_up;
        if (sta.dv) begin
          cmd.wr_op = WR_PURGE;
          if (sta.last_dk) begin
            cmd.purge_fin = 1'b1;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_DUMP_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DUMP_WAIT;
      end
      S_DUMP_WAIT: begin
        // hold the read entry until the output register frees up
        if (sta.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          state_nxt     = sta.last_dk ? S_IDLE : S_DUMP_RD;
        end
      end
      S_EMIT: begin
        if (sta.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/mrt_datapath.sv
// Datapath of the mesh route table engine: table memory, counters, result register.
module mrt_datapath import mrt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_t        in_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  cmd_t       cmd,
  output sta_t       sta,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ent_t mem [DEPTH];

  logic [7:0]    own_id_r;
  logic [2:0]    act_r;
  logic [7:0]    node_r, cnt_r, src_r, hop_r;
  logic [7:0]    nh_r;
  logic          full_r;
  logic [CW-1:0] used_r, idx_r, w_r;
  logic [AW-1:0] dk_r;
  logic          dv_r;
  ent_t          rd_data_r;
  logic          out_valid_r;
  out_t          out_data_r;

  logic [CW-1:0] idx_m1;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  ent_t          wr_data, new_ent;
  logic          upd_needed;
  logic [15:0]   used16, blen16;
  logic [7:0]    cnt_in;

  assign idx_m1  = idx_r - CW'(1);
  assign rd_addr = cmd.rd_down ? idx_m1[AW-1:0] : idx_r[AW-1:0];
  assign new_ent = '{active: 1'b1, node: node_r, hops: cnt_r, next_hop: hop_r};

  assign upd_needed = rd_data_r.active ? (rd_data_r.hops > cnt_r) : (src_r != own_id_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dk_r;
    wr_data = rd_data_r;
    case (cmd.wr_op)
      WR_UPDATE: begin
        wr_en   = upd_needed;
        wr_data = new_ent;
      end
      WR_AGE: begin
        wr_en          = 1'b1;
        wr_data.active = 1'b0;
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = dk_r + AW'(1);
      end
      WR_PURGE: begin
        wr_en   = rd_data_r.active;
        wr_addr = w_r[AW-1:0];
      end
      WR_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_ent;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      dk_r      <= rd_addr;
    end
  end

  assign cnt_in = (in_data.hops == 8'hFF) ? 8'hFF : in_data.hops + 8'd1;

  // latch the item with its count, source and next hop already chosen
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r  <= in_data.action;
      node_r <= in_data.node;
      if (in_data.action == ACT_ADV) begin
        cnt_r <= cnt_in;
        src_r <= in_data.adv_source;
        hop_r <= in_data.sender;
      end else begin
        cnt_r <= 8'd1;
        src_r <= 8'd0;
        hop_r <= in_data.node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= OWN_ID_RST;
      used_r      <= '0;
      idx_r       <= '0;
      w_r         <= '0;
      dv_r        <= 1'b0;
      nh_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) own_id_r <= cfg_wr_data;
      dv_r <= cmd.rd_en;

      if (cmd.idx_init_up) idx_r <= '0;
      else if (cmd.idx_init_down) idx_r <= used_r;
      else if (cmd.rd_en) idx_r <= cmd.rd_down ? idx_m1 : idx_r + CW'(1);

      if (cmd.load_item) begin
        nh_r   <= '0;
        full_r <= 1'b0;
      end else begin
        if (cmd.nh_latch) nh_r <= rd_data_r.next_hop;
        if (cmd.full_set) full_r <= 1'b1;
      end

      if (cmd.idx_init_up) w_r <= '0;
      else if (cmd.wr_op == WR_PURGE && rd_data_r.active) w_r <= w_r + CW'(1);

      if (cmd.wr_op == WR_INSERT) used_r <= used_r + CW'(1);
      else if (cmd.purge_fin) used_r <= w_r + CW'(rd_data_r.active);

      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign used16 = 16'(used_r);
  assign blen16 = used16 * 16'd3 + 16'd2;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.beacon_length <= blen16[5:0];
      out_data_r.entry_count   <= used16[4:0];
      if (cmd.out_entry) begin
        out_data_r.next_hop       <= '0;
        out_data_r.entry_node     <= rd_data_r.node;
        out_data_r.entry_hops     <= rd_data_r.hops;
        out_data_r.entry_next_hop <= rd_data_r.next_hop;
        out_data_r.entry_valid    <= 1'b1;
        out_data_r.table_full     <= 1'b0;
        out_data_r.last           <= sta.last_dk;
      end else begin
        out_data_r.next_hop       <= nh_r;
        out_data_r.entry_node     <= '0;
        out_data_r.entry_hops     <= '0;
        out_data_r.entry_next_hop <= '0;
        out_data_r.entry_valid    <= 1'b0;
        out_data_r.table_full     <= full_r;
        out_data_r.last           <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sta.action      = act_r;
    sta.adv_skip    = (node_r == 8'd0) || (node_r == own_id_r);
    sta.used_zero   = (used_r == '0);
    sta.table_full  = (used_r == CW'(DEPTH));
    sta.idx_more_up = (idx_r < used_r);
    sta.idx_nz      = (idx_r != '0);
    sta.dv          = dv_r;
    sta.match       = (rd_data_r.node == node_r);
    sta.last_dk     = (CW'(dk_r) + CW'(1) == used_r);
    sta.dk_zero     = (dk_r == '0);
    sta.src_own     = (src_r == own_id_r);
    sta.out_free    = !out_valid_r || !out_stall;
  end

endmodule

// File: dv/mesh_route_table_engine_tb.sv
// Self-checking testbench for the mesh route table engine, with its own route table predictor.
`timescale 1ns / 100ps

module mesh_route_table_engine_tb;
  import mrt_pkg::*;

  localparam int TBL_DEPTH = DEPTH_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  // Predicted route table, newest entry at index 0
  logic [7:0] rt_node [TBL_DEPTH];
  logic [7:0] rt_hops [TBL_DEPTH];
  logic [7:0] rt_nh [TBL_DEPTH];
  logic rt_act [TBL_DEPTH];
  int rt_used = 0;
  logic [7:0] own_id_m = OWN_ID_RST;

  in_t action_q [$];
  out_t route_result_q [$];
  int queued_cnt = 0;
  int sent_cnt = 0;
  int mismatch_cnt = 0;
  int in_gap = 0;
  int stall_left = 0;
  logic calm = 1'b0;

  mesh_route_table_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Returns 1 when the new entry is dropped on a full table
  function automatic logic route_add(logic [7:0] n, logic [7:0] c, logic [7:0] s,
                                     logic [7:0] h);
    int k;
    int hit;
    hit = -1;
    for (k = rt_used - 1; k >= 0; k--)
      if (rt_node[k] == n) hit = k;
    if (hit >= 0) begin
      if (rt_act[hit]) begin
        if (rt_hops[hit] > c) begin
          rt_hops[hit] = c;
          rt_nh[hit] = h;
        end
      end else if (s != own_id_m) begin
        rt_act[hit] = 1'b1;
        rt_hops[hit] = c;
        rt_nh[hit] = h;
      end
      return 1'b0;
    end
    // a path through this node only seeds an empty table
    if (rt_used != 0 && s == own_id_m) return 1'b0;
    if (rt_used >= TBL_DEPTH) return 1'b1;
    for (k = rt_used; k > 0; k--) begin
      rt_node[k] = rt_node[k - 1];
      rt_hops[k] = rt_hops[k - 1];
      rt_nh[k] = rt_nh[k - 1];
      rt_act[k] = rt_act[k - 1];
    end
    rt_node[0] = n;
    rt_hops[0] = c;
    rt_nh[0] = h;
    rt_act[0] = 1'b1;
    rt_used++;
    return 1'b0;
  endfunction

  task automatic route_table_step(in_t it);
    logic [7:0] nh;
    logic full;
    logic [7:0] cost;
    int k;
    int w;
    out_t r;
    nh = '0;
    full = 1'b0;
    case (it.action)
      ACT_HEARD: full = route_add(it.node, 8'd1, 8'd0, it.node);
      ACT_ADV: begin
        cost = (it.hops == 8'hFF) ? 8'hFF : it.hops + 8'd1;
        if (it.node != 8'd0 && it.node != own_id_m)
          full = route_add(it.node, cost, it.adv_source, it.sender);
      end
      ACT_LOOKUP: begin
        for (k = rt_used - 1; k >= 0; k--)
          if (rt_node[k] == it.node) nh = rt_nh[k];
      end
      ACT_AGE: begin
        for (k = 0; k < rt_used; k++) rt_act[k] = 1'b0;
      end
      ACT_PURGE: begin
        // compact active entries toward the head, keep order
        w = 0;
        for (k = 0; k < rt_used; k++) begin
          if (rt_act[k]) begin
            rt_node[w] = rt_node[k];
            rt_hops[w] = rt_hops[k];
            rt_nh[w] = rt_nh[k];
            rt_act[w] = 1'b1;
            w++;
          end
        end
        rt_used = w;
      end
      default: ;
    endcase
    r = '0;
    r.beacon_length = 6'(2 + 3 * rt_used);
    r.entry_count = 5'(rt_used);
    if (it.action == ACT_DUMP && rt_used > 0) begin
      for (k = 0; k < rt_used; k++) begin
        r.entry_node = rt_node[k];
        r.entry_hops = rt_hops[k];
        r.entry_next_hop = rt_nh[k];
        r.entry_valid = 1'b1;
        r.last = (k == rt_used - 1);
        route_result_q.push_back(r);
      end
    end else begin
      r.next_hop = nh;
      r.table_full = full;
      r.last = 1'b1;
      route_result_q.push_back(r);
    end
  endtask

  function automatic in_t mk_item(logic [2:0] act, logic [7:0] node, logic [7:0] hops,
                                  logic [7:0] src, logic [7:0] sender);
    in_t it;
    it.action = act;
    it.node = node;
    it.hops = hops;
    it.adv_source = src;
    it.sender = sender;
    return it;
  endfunction

  task automatic push_item(in_t it);
    action_q.push_back(it);
    queued_cnt++;
  endtask

  // Random item, biased to a small node pool so updates and lookups hit
  function automatic in_t rand_item();
    in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.node = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    if ($urandom_range(0, 9) == 0) it.node = own_id_m;
    case ($urandom_range(0, 4))
      0: it.hops = 8'd0;
      1: it.hops = 8'd254;
      2: it.hops = 8'd255;
      3: it.hops = 8'($urandom);
      default: it.hops = 8'($urandom_range(0, 6));
    endcase
    it.adv_source = ($urandom_range(0, 3) == 0) ? own_id_m : 8'($urandom);
    it.sender = 8'($urandom);
    if (pick < 25) it.action = ACT_HEARD;
    else if (pick < 60) it.action = ACT_ADV;
    else if (pick < 74) it.action = ACT_LOOKUP;
    else if (pick < 81) it.action = ACT_AGE;
    else if (pick < 87) it.action = ACT_PURGE;
    else if (pick < 96) it.action = ACT_DUMP;
    else it.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
    return it;
  endfunction

  // Overfill the table, dump it full, then age and purge part of it away
  task automatic queue_fill();
    logic [7:0] base;
    int k;
    base = 8'($urandom_range(20, 200));
    for (k = 0; k < TBL_DEPTH + 2; k++)
      push_item(mk_item(ACT_HEARD, base + 8'(k), 8'($urandom), 8'($urandom), 8'($urandom)));
    push_item(mk_item(ACT_DUMP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    push_item(mk_item(ACT_ADV, base + 8'd40, 8'($urandom), own_id_m + 8'd1, 8'($urandom)));
    push_item(mk_item(ACT_AGE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    push_item(mk_item(ACT_HEARD, base + 8'd3, 8'($urandom), 8'($urandom), 8'($urandom)));
    push_item(mk_item(ACT_PURGE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic queue_random(int count);
    repeat (count) push_item(rand_item());
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sent_cnt != queued_cnt || route_result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_id(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_id_m = v;
  endtask

  // Input driver: hold the payload until the transfer, idle in random bursts
  always @(posedge clk) begin : drive_proc
    in_t nxt_data;
    logic nxt_valid;
    nxt_data = in_data;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        route_table_step(in_data);
        sent_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 3) - 1;
        end else if (action_q.size() != 0) begin
          nxt_data = action_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Result monitor and stall generator
  always @(posedge clk) begin : watch_proc
    logic nxt_stall;
    out_t want;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (route_result_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = route_result_q.pop_front();
          check_field("next_hop", out_data.next_hop, want.next_hop);
          check_field("entry_node", out_data.entry_node, want.entry_node);
          check_field("entry_hops", out_data.entry_hops, want.entry_hops);
          check_field("entry_next_hop", out_data.entry_next_hop, want.entry_next_hop);
          check_field("entry_valid", out_data.entry_valid, want.entry_valid);
          check_field("beacon_length", out_data.beacon_length, want.beacon_length);
          check_field("entry_count", out_data.entry_count, want.entry_count);
          check_field("table_full", out_data.table_full, want.table_full);
          check_field("last", out_data.last, want.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        nxt_stall = 1'b1;
      end
    end
    out_stall <= nxt_stall;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with own id at its reset value
    push_item(mk_item(ACT_DUMP, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_LOOKUP, 8'd5, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_ADV, 8'd20, 8'd7, 8'd1, 8'd33));
    push_item(mk_item(ACT_HEARD, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_HEARD, 8'd255, 8'd255, 8'd255, 8'd255));
    push_item(mk_item(ACT_ADV, 8'd0, 8'd2, 8'd3, 8'd4));
    push_item(mk_item(ACT_ADV, 8'd1, 8'd2, 8'd3, 8'd4));
    push_item(mk_item(ACT_ADV, 8'd10, 8'd255, 8'd0, 8'd7));
    push_item(mk_item(ACT_ADV, 8'd11, 8'd0, 8'd1, 8'd4));
    push_item(mk_item(ACT_ADV, 8'd10, 8'd3, 8'd5, 8'd9));
    push_item(mk_item(ACT_ADV, 8'd10, 8'd8, 8'd5, 8'd12));
    push_item(mk_item(ACT_LOOKUP, 8'd10, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_LOOKUP, 8'd99, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_AGE, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_LOOKUP, 8'd20, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_ADV, 8'd10, 8'd0, 8'd1, 8'd2));
    push_item(mk_item(ACT_HEARD, 8'd255, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_ADV, 8'd20, 8'd254, 8'd200, 8'd77));
    push_item(mk_item(ACT_DUMP, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_PURGE, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_SPARE_LO, 8'd255, 8'd255, 8'd255, 8'd255));
    push_item(mk_item(ACT_SPARE_HI, 8'd20, 8'd255, 8'd255, 8'd255));
    push_item(mk_item(ACT_DUMP, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_AGE, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_PURGE, 8'd0, 8'd0, 8'd0, 8'd0));
    push_item(mk_item(ACT_DUMP, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_fill();
    queue_random(45);
    wait_drained();

    write_own_id(8'd0);
    queue_fill();
    queue_random(45);
    wait_drained();

    write_own_id(8'd255);
    queue_random(20);
    queue_fill();
    queue_random(25);
    wait_drained();

    write_own_id(8'($urandom));
    queue_fill();
    queue_random(45);
    wait_drained();

    // final stretch runs without idling on either side
    write_own_id(8'($urandom_range(2, 254)));
    calm = 1'b1;
    queue_random(20);
    queue_fill();
    queue_random(25);
    wait_drained();

    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
